/* rtl/vmt_pkg.sv */
// Shared types, widths and codes for the vertex matrix transform unit.
// Used by every module in rtl; depends on nothing.
package vmt_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int COEF_WIDTH  = 16;
   localparam int CRD_FRAC    = COORD_WIDTH / 2;
   localparam int CEF_FRAC    = COEF_WIDTH / 2;
   localparam int LANE_WIDTH  = 16;
   localparam int COL_WIDTH   = 64;
   localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int ACC_WIDTH   = SUM_WIDTH - CEF_FRAC;
   localparam int REM_WIDTH   = ACC_WIDTH;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = COORD_WIDTH / DIV_STEPS;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [1:0] MODE_FULL       = 2'd0;
   localparam logic [1:0] MODE_ROTATE     = 2'd1;
   localparam logic [1:0] MODE_INV_ROTATE = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COL1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COL2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COL3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COL4 = 3'd4;

   localparam logic [COL_WIDTH-1:0] COL1_RESET = 64'd256;
   localparam logic [COL_WIDTH-1:0] COL2_RESET = 64'd16777216;
   localparam logic [COL_WIDTH-1:0] COL3_RESET = 64'd1099511627776;
   localparam logic [COL_WIDTH-1:0] COL4_RESET = 64'd72057594037927936;

   typedef logic [3:0][COL_WIDTH-1:0] matrix_type;
   typedef logic [3:0][ACC_WIDTH-1:0] acc_vec_type;

   typedef struct packed {
      logic                        full;
      logic                        zdiv;
      logic                        rot_sat;
      logic [2:0][COORD_WIDTH-1:0] rot;
      logic [2:0]                  neg;
      logic [2:0]                  ovf;
   } side_type;

   function automatic logic signed [COEF_WIDTH-1:0] coef(input matrix_type m,
                                                         input int row, input int col);
      coef = m[col][row*LANE_WIDTH +: COEF_WIDTH];
   endfunction

endpackage

/* rtl/vmt_mac.sv */
// Two-stage multiply and accumulate: products, then sums floored to the coordinate fraction.
// Depends on vmt_pkg.
module vmt_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [2:0][vmt_pkg::COORD_WIDTH-1:0] in_point,
   input  logic [1:0]                           mode,
   input  vmt_pkg::matrix_type                  matrix,
   output logic                                 out_valid,
   output logic                                 out_full,
   output vmt_pkg::acc_vec_type                 out_acc
);

   logic [3:0][3:0][vmt_pkg::PROD_WIDTH-1:0] prod_in, prod_ff;
   logic                                     a_valid_ff, a_full_ff, a_full_in;
   logic                                     b_valid_ff, b_full_ff;
   vmt_pkg::acc_vec_type                     acc_in, acc_ff;

   assign a_full_in = !(mode == vmt_pkg::MODE_ROTATE || mode == vmt_pkg::MODE_INV_ROTATE);

   always_comb begin
      logic signed [vmt_pkg::COORD_WIDTH-1:0] v;
      logic signed [vmt_pkg::COEF_WIDTH-1:0]  c;
      logic signed [vmt_pkg::PROD_WIDTH-1:0]  p;
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            v = in_point[k];
            c = (mode == vmt_pkg::MODE_INV_ROTATE) ? vmt_pkg::coef(matrix, j, k)
                                                   : vmt_pkg::coef(matrix, k, j);
            p = v * c;
            prod_in[j][k] = p;
         end
         c = vmt_pkg::coef(matrix, 3, j);
         prod_in[j][3] = a_full_in
            ? {{(vmt_pkg::PROD_WIDTH-vmt_pkg::COEF_WIDTH-vmt_pkg::CRD_FRAC){c[vmt_pkg::COEF_WIDTH-1]}},
               c, {vmt_pkg::CRD_FRAC{1'b0}}}
            : '0;
      end
   end

   always_comb begin
      logic signed [vmt_pkg::SUM_WIDTH-1:0] s;
      for (int j = 0; j < 4; j++) begin
         s = '0;
         for (int k = 0; k < 4; k++) begin
            s = s + vmt_pkg::SUM_WIDTH'($signed(prod_ff[j][k]));
         end
         acc_in[j] = s[vmt_pkg::SUM_WIDTH-1:vmt_pkg::CEF_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         a_full_ff <= a_full_in;
         acc_ff    <= acc_in;
         b_full_ff <= a_full_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_full  = b_full_ff;
   assign out_acc   = acc_ff;

endmodule

/* rtl/vmt_div.sv */
// Pipelined restoring divider for one lane, two quotient bits per stage.
// Depends on vmt_pkg.
module vmt_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [vmt_pkg::REM_WIDTH-1:0]     rem_start,
   input  logic [vmt_pkg::REM_WIDTH-1:0]     divisor,
   input  logic [vmt_pkg::COORD_WIDTH-1:0]   low_bits,
   output logic [vmt_pkg::COORD_WIDTH-1:0]   quotient
);

   localparam int N = vmt_pkg::DIV_STAGES;

   logic [vmt_pkg::REM_WIDTH-1:0]   rem_in [N], rem_ff [N];
   logic [vmt_pkg::REM_WIDTH-1:0]   ud_in  [N], ud_ff  [N];
   logic [vmt_pkg::COORD_WIDTH-1:0] nb_in  [N], nb_ff  [N];
   logic [vmt_pkg::COORD_WIDTH-1:0] quo_in [N], quo_ff [N];

   always_comb begin
      logic [vmt_pkg::REM_WIDTH:0]     t;
      logic [vmt_pkg::REM_WIDTH-1:0]   r, d;
      logic [vmt_pkg::COORD_WIDTH-1:0] nb, q;
      for (int s = 0; s < N; s++) begin
         if (s == 0) begin
            r = rem_start; d = divisor; nb = low_bits; q = '0;
         end else begin
            r = rem_ff[s-1]; d = ud_ff[s-1]; nb = nb_ff[s-1]; q = quo_ff[s-1];
         end
         for (int i = 0; i < vmt_pkg::DIV_STEPS; i++) begin
            t  = {r, nb[vmt_pkg::COORD_WIDTH-1]};
            nb = {nb[vmt_pkg::COORD_WIDTH-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
               t = t - {1'b0, d};
               q = {q[vmt_pkg::COORD_WIDTH-2:0], 1'b1};
            end else begin
               q = {q[vmt_pkg::COORD_WIDTH-2:0], 1'b0};
            end
            r = t[vmt_pkg::REM_WIDTH-1:0];
         end
         rem_in[s] = r; ud_in[s] = d; nb_in[s] = nb; quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < N; s++) begin
            rem_ff[s] <= rem_in[s];
            ud_ff[s]  <= ud_in[s];
            nb_ff[s]  <= nb_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quotient = quo_ff[N-1];

endmodule

/* rtl/vertex_matrix_transform_unit.sv */
// Vertex matrix transform unit: 4x4 homogeneous transform, rotate and inverse rotate.
// One transaction is accepted per cycle while the pipeline is not held.
// The pipeline is two multiply/accumulate stages, one preparation stage, the
// sixteen-stage divider and the output register. The whole pipeline holds while a result waits.
// Synchronous reset empties the pipeline and loads mode 0 and the identity matrix.
module vertex_matrix_transform_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [vmt_pkg::COORD_WIDTH-1:0]  req_point_x,
   input  logic signed [vmt_pkg::COORD_WIDTH-1:0]  req_point_y,
   input  logic signed [vmt_pkg::COORD_WIDTH-1:0]  req_point_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [vmt_pkg::COORD_WIDTH-1:0]  rsp_result_x,
   output logic signed [vmt_pkg::COORD_WIDTH-1:0]  rsp_result_y,
   output logic signed [vmt_pkg::COORD_WIDTH-1:0]  rsp_result_z,
   output logic                                    rsp_zero_divisor,
   output logic                                    rsp_saturated,
   input  logic                                    csr_write_enable,
   input  logic [vmt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [vmt_pkg::COL_WIDTH-1:0]           csr_write_data
);

   localparam int CW = vmt_pkg::COORD_WIDTH;
   localparam int AW = vmt_pkg::ACC_WIDTH;
   localparam int N  = vmt_pkg::DIV_STAGES;
   localparam logic [CW-1:0] POS_LIM = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] NEG_LIM = {1'b1, {(CW-1){1'b0}}};

   logic                 en;
   logic [1:0]           mode_ff;
   vmt_pkg::matrix_type  matrix_ff;
   logic                 mac_valid, mac_full;
   vmt_pkg::acc_vec_type mac_acc;

   logic                         c_valid_ff;
   vmt_pkg::side_type            c_side_ff, c_side_in;
   logic [2:0][AW-1:0]           c_rem_ff, c_rem_in;
   logic [2:0][CW-1:0]           c_nb_ff, c_nb_in;
   logic [AW-1:0]                c_ud_ff, c_ud_in;
   logic                         d_valid_ff [N];
   vmt_pkg::side_type            d_side_ff  [N];
   logic [2:0][CW-1:0]           quo;

   logic                 out_valid_ff;
   logic [2:0][CW-1:0]   out_res_ff, out_res_in;
   logic                 out_zdiv_ff, out_zdiv_in, out_sat_ff, out_sat_in;

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= vmt_pkg::MODE_FULL;
         matrix_ff[0] <= vmt_pkg::COL1_RESET;
         matrix_ff[1] <= vmt_pkg::COL2_RESET;
         matrix_ff[2] <= vmt_pkg::COL3_RESET;
         matrix_ff[3] <= vmt_pkg::COL4_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            vmt_pkg::CSR_MODE: mode_ff      <= csr_write_data[1:0];
            vmt_pkg::CSR_COL1: matrix_ff[0] <= csr_write_data;
            vmt_pkg::CSR_COL2: matrix_ff[1] <= csr_write_data;
            vmt_pkg::CSR_COL3: matrix_ff[2] <= csr_write_data;
            vmt_pkg::CSR_COL4: matrix_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   vmt_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_point  ({req_point_z, req_point_y, req_point_x}),
      .mode      (mode_ff),
      .matrix    (matrix_ff),
      .out_valid (mac_valid),
      .out_full  (mac_full),
      .out_acc   (mac_acc)
   );

   always_comb begin
      logic signed [AW-1:0] a;
      logic [AW-1:0]        un, ud;
      logic                 dn;
      c_side_in      = '0;
      c_side_in.full = mac_full;
      c_side_in.zdiv = mac_full && (mac_acc[3] == '0);
      dn = mac_acc[3][AW-1];
      ud = dn ? AW'(-$signed(mac_acc[3])) : mac_acc[3];
      c_ud_in = ud;
      for (int j = 0; j < 3; j++) begin
         a = mac_acc[j];
         if (a > $signed(AW'($signed(POS_LIM)))) begin
            c_side_in.rot[j] = POS_LIM;
            c_side_in.rot_sat = 1'b1;
         end else if (a < $signed(AW'($signed(NEG_LIM)))) begin
            c_side_in.rot[j] = NEG_LIM;
            c_side_in.rot_sat = 1'b1;
         end else begin
            c_side_in.rot[j] = a[CW-1:0];
         end
         un = a[AW-1] ? AW'(-a) : AW'(a);
         c_side_in.neg[j] = a[AW-1] ^ dn;
         c_side_in.ovf[j] = {un, {vmt_pkg::CRD_FRAC{1'b0}}} >= {ud, {CW{1'b0}}};
         c_rem_in[j] = AW'(un[AW-1:vmt_pkg::CRD_FRAC]);
         c_nb_in[j]  = {un[vmt_pkg::CRD_FRAC-1:0], {(CW-vmt_pkg::CRD_FRAC){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         for (int s = 0; s < N; s++) d_valid_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff    <= mac_valid;
         d_valid_ff[0] <= c_valid_ff;
         for (int s = 1; s < N; s++) d_valid_ff[s] <= d_valid_ff[s-1];
         out_valid_ff  <= d_valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_side_ff    <= c_side_in;
         c_rem_ff     <= c_rem_in;
         c_nb_ff      <= c_nb_in;
         c_ud_ff      <= c_ud_in;
         d_side_ff[0] <= c_side_ff;
         for (int s = 1; s < N; s++) d_side_ff[s] <= d_side_ff[s-1];
         out_res_ff   <= out_res_in;
         out_zdiv_ff  <= out_zdiv_in;
         out_sat_ff   <= out_sat_in;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      vmt_div u_div (
         .clock     (clock),
         .en        (en),
         .rem_start (c_rem_ff[g]),
         .divisor   (c_ud_ff),
         .low_bits  (c_nb_ff[g]),
         .quotient  (quo[g])
      );
   end

   always_comb begin
      vmt_pkg::side_type sd;
      logic [CW-1:0]     lim, mag;
      logic              over, any_over;
      sd = d_side_ff[N-1];
      any_over = 1'b0;
      for (int j = 0; j < 3; j++) begin
         lim  = sd.neg[j] ? NEG_LIM : POS_LIM;
         over = sd.ovf[j] || (quo[j] > lim);
         mag  = over ? lim : quo[j];
         any_over = any_over | over;
         if (!sd.full) out_res_in[j] = sd.rot[j];
         else if (sd.zdiv) out_res_in[j] = '0;
         else out_res_in[j] = sd.neg[j] ? CW'(-mag) : mag;
      end
      out_zdiv_in = sd.full && sd.zdiv;
      if (!sd.full) out_sat_in = sd.rot_sat;
      else out_sat_in = !sd.zdiv && any_over;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_x     = out_res_ff[0];
   assign rsp_result_y     = out_res_ff[1];
   assign rsp_result_z     = out_res_ff[2];
   assign rsp_zero_divisor = out_zdiv_ff;
   assign rsp_saturated    = out_sat_ff;

endmodule
